// File: sv/tlls_pkg.sv
// Shared types, constants and event codes for the tip, lift and landing supervisor.
// No dependencies; imported by every module of the block.
package tlls_pkg;

  localparam int unsigned PitchW = 17;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned AccelW = 14;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 8;

  // Fixed thresholds, Q8.8
  localparam logic [SpeedW-1:0] LiftSpeedMax = 16'd2048;  // 8.0
  localparam logic [PitchW-1:0] LiftPitchMax = 17'd1280;  // 5.0 deg
  localparam logic [PitchW-1:0] SpinPitchMax = 17'd2560;  // 10.0 deg
  localparam logic [PitchW-1:0] LandPitchMax = 17'd1280;  // 5.0 deg
  localparam logic [PitchW:0]   StillDeltaMax = 18'd204;  // just under 0.8 deg

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_OVERSPEED = 3'd1,
    EV_TIPPED    = 3'd2,
    EV_LIFT_ACC  = 3'd3,
    EV_LIFT_SPIN = 3'd4,
    EV_LANDED    = 3'd5
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OVERSPEED_LIMIT  = 3'd0,
    REG_FALL_PITCH_LIMIT = 3'd1,
    REG_LIFT_ACCEL_LIMIT = 3'd2,
    REG_ACCEL_CHECK_EN   = 3'd3,
    REG_SPIN_SPEED_LIMIT = 3'd4,
    REG_SPIN_TICK_LIMIT  = 3'd5,
    REG_LANDING_PERIOD   = 3'd6,
    REG_SETTLE_SAMPLES   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] overspeed_limit;
    logic [15:0] fall_pitch_limit;
    logic [12:0] lift_accel_limit;
    logic        accel_check_enable;
    logic [14:0] spin_speed_limit;
    logic [7:0]  spin_tick_limit;
    logic [7:0]  landing_period;
    logic [3:0]  settle_samples;
  } cfg_t;

  typedef struct packed {
    logic              enabled;
    logic [7:0]        spin_cnt;
    logic [7:0]        period_cnt;
    logic [3:0]        still_cnt;
    logic [PitchW-1:0] prev_pitch;
  } sup_state_t;

endpackage

// File: sv/tlls_checks.sv
// Per-tick decision logic: safety cuts, spin counting and landing detection.
// Purely combinational; depends on tlls_pkg.
module tlls_checks import tlls_pkg::*; (
  input  cfg_t                     cfg_i,
  input  sup_state_t               state_i,
  input  logic signed [PitchW-1:0] pitch_i,
  input  logic signed [SpeedW-1:0] speed_i,
  input  logic signed [AccelW-1:0] accel_z_i,
  input  logic                     request_open_i,
  output sup_state_t               state_o,
  output event_e                   event_o
);

  logic [PitchW-1:0] ap;
  logic [SpeedW-1:0] as_mag;
  logic signed [PitchW:0] delta;
  logic [PitchW:0]   delta_mag;
  logic en_req, cut_os, cut_tip, cut_acc, spinning, cut_spin, en_after_cuts;
  logic [8:0] period_nx;
  logic [4:0] still_nx;

  always_comb begin
    ap        = pitch_i[PitchW-1] ? PitchW'(-pitch_i) : PitchW'(pitch_i);
    as_mag    = speed_i[SpeedW-1] ? SpeedW'(-speed_i) : SpeedW'(speed_i);
    delta     = {pitch_i[PitchW-1], pitch_i} - {state_i.prev_pitch[PitchW-1], state_i.prev_pitch};
    delta_mag = delta[PitchW] ? (PitchW+1)'(-delta) : (PitchW+1)'(delta);

    en_req  = state_i.enabled | request_open_i;
    cut_os  = en_req && (as_mag > {1'b0, cfg_i.overspeed_limit});
    cut_tip = en_req && !cut_os && (ap > {1'b0, cfg_i.fall_pitch_limit});
    cut_acc = en_req && !cut_os && !cut_tip && cfg_i.accel_check_enable &&
              !accel_z_i[AccelW-1] && (accel_z_i[AccelW-2:0] > cfg_i.lift_accel_limit) &&
              (as_mag < LiftSpeedMax) && (ap < LiftPitchMax);
    spinning = en_req && !cut_os && !cut_tip && !cut_acc &&
               (as_mag > {1'b0, cfg_i.spin_speed_limit}) && (ap < SpinPitchMax);
    cut_spin = spinning && (state_i.spin_cnt >= cfg_i.spin_tick_limit);
    en_after_cuts = en_req && !cut_os && !cut_tip && !cut_acc && !cut_spin;

    state_o = state_i;
    state_o.enabled = en_after_cuts;
    state_o.spin_cnt = (spinning && !cut_spin) ? state_i.spin_cnt + 8'd1 : 8'd0;

    event_o = EV_NONE;
    if (cut_os) event_o = EV_OVERSPEED;
    else if (cut_tip) event_o = EV_TIPPED;
    else if (cut_acc) event_o = EV_LIFT_ACC;
    else if (cut_spin) event_o = EV_LIFT_SPIN;

    period_nx = {1'b0, state_i.period_cnt} + 9'd1;
    still_nx  = {1'b0, state_i.still_cnt} + 5'd1;

    // Landing runs whenever drive ends up off, including a tick that just cut it
    if (!en_after_cuts) begin
      if (ap <= LandPitchMax) begin
        if (period_nx >= {1'b0, cfg_i.landing_period}) begin
          state_o.period_cnt = 8'd0;
          if (delta_mag <= StillDeltaMax) begin
            if (still_nx >= {1'b0, cfg_i.settle_samples}) begin
              state_o.still_cnt = 4'd0;
              state_o.enabled   = 1'b1;
              event_o           = EV_LANDED;
            end else begin
              state_o.still_cnt = still_nx[3:0];
            end
          end else begin
            state_o.still_cnt = 4'd0;
          end
          state_o.prev_pitch = pitch_i;
        end else begin
          state_o.period_cnt = period_nx[7:0];
        end
      end else begin
        state_o.period_cnt = 8'd0;
        state_o.still_cnt  = 4'd0;
      end
    end
  end

endmodule

// File: sv/tip_lift_landing_supervisor_core.sv
// Top level of the tip, lift and landing supervisor: stream ports, configuration
// registers, supervisor state and the result register. Depends on tlls_pkg, tlls_checks.
//
// Usage
//   One input beat per control tick on s_axis; one result beat per input beat on
//   m_axis, in order. Each beat carries pitch, wheel speed, vertical acceleration
//   and the re-enable request; the result gives the motor enable flag after the
//   tick and an event code (none, overspeed, tipped, lifted by accel, lifted by
//   spin, landed).
//   Latency: the result is valid the cycle after the input beat is taken.
//   Throughput: one beat per clock while m_axis takes results. The decision logic
//   sits between the input port and the result register, and the supervisor state
//   register closes its loop with no other register, so successive ticks follow without gaps.
//   Stall: s_axis_tready stays high while the result register is empty or is
//   being drained this cycle; a stalled m_axis holds its beat and back-pressures
//   the input only while that beat waits.
//   Reset (rst_ni low, asynchronous): drive enabled, all counters and the stored
//   pitch cleared, registers back to their defaults, no result pending.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i; the user must
//   write only while the block is idle, which the block itself does not enforce.
module tip_lift_landing_supervisor_core import tlls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // pitch[16:0], speed[32:17], accel_z[46:33],
                                             // request_open[47]
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // drive_enabled[0], event_code[3:1], zero[7:4]
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  sup_state_t state_q, state_d;
  event_e     event_d, event_q;
  logic       drive_q;
  logic       out_valid_q;
  logic       in_beat;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  tlls_checks u_checks (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .pitch_i        (s_axis_tdata[16:0]),
    .speed_i        (s_axis_tdata[32:17]),
    .accel_z_i      (s_axis_tdata[46:33]),
    .request_open_i (s_axis_tdata[47]),
    .state_o        (state_d),
    .event_o        (event_d)
  );

  // Configuration registers, masked to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overspeed_limit    <= 15'd25600;
      cfg_q.fall_pitch_limit   <= 16'd16640;
      cfg_q.lift_accel_limit   <= 13'd512;
      cfg_q.accel_check_enable <= 1'b1;
      cfg_q.spin_speed_limit   <= 15'd17920;
      cfg_q.spin_tick_limit    <= 8'd20;
      cfg_q.landing_period     <= 8'd70;
      cfg_q.settle_samples     <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OVERSPEED_LIMIT:  cfg_q.overspeed_limit    <= cfg_wdata_i[14:0];
        REG_FALL_PITCH_LIMIT: cfg_q.fall_pitch_limit   <= cfg_wdata_i;
        REG_LIFT_ACCEL_LIMIT: cfg_q.lift_accel_limit   <= cfg_wdata_i[12:0];
        REG_ACCEL_CHECK_EN:   cfg_q.accel_check_enable <= cfg_wdata_i[0];
        REG_SPIN_SPEED_LIMIT: cfg_q.spin_speed_limit   <= cfg_wdata_i[14:0];
        REG_SPIN_TICK_LIMIT:  cfg_q.spin_tick_limit    <= cfg_wdata_i[7:0];
        REG_LANDING_PERIOD:   cfg_q.landing_period     <= cfg_wdata_i[7:0];
        REG_SETTLE_SAMPLES:   cfg_q.settle_samples     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Supervisor state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.enabled    <= 1'b1;
      state_q.spin_cnt   <= 8'd0;
      state_q.period_cnt <= 8'd0;
      state_q.still_cnt  <= 4'd0;
      state_q.prev_pitch <= '0;
    end else if (in_beat) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      drive_q <= state_d.enabled;
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, event_q, drive_q};

  // A cut event always leaves drive off
  a_cut_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (event_q == EV_OVERSPEED || event_q == EV_TIPPED ||
                      event_q == EV_LIFT_ACC || event_q == EV_LIFT_SPIN) |-> !drive_q)
    else $error("cut event reported with drive still enabled");

  // Landing always re-enables drive
  a_land_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && event_q == EV_LANDED |-> drive_q)
    else $error("landing reported with drive off");

  // Spin count is meaningful only while enabled
  a_spin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.enabled |-> state_q.spin_cnt == 8'd0)
    else $error("spin counter running while disabled");

  // Result flag tracks the stored state
  a_flag_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> m_axis_tvalid && (drive_q == state_q.enabled))
    else $error("result flag differs from supervisor state");

endmodule
